### rtl/gwmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwmf_pkg : shared types and constants of the gear window min-hash feature
// Word formats of both channels, internal command word, mixer handshake
// structs, state encodings and the hash constants.
// ----------------------------------------------------------------------------
package gwmf_pkg;

    // configuration register
    localparam int                 CFG_W        = 7;
    localparam logic [CFG_W-1:0]   WINDOW_RESET = 7'd32;

    // depth of the command queue between front and back
    localparam int                 QUEUE_DEPTH  = 4;

    // splitmix64 constants
    localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

    // FNV-1a 64 prime 2^40 + 0x1b3: product is a shift + narrow multiply; nonstd basis
    localparam logic [63:0] FNV_BASIS       = 64'd1469598103934665603;
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [63:0] FNV_PRIME_LO    = 64'h0000_0000_0000_01b3;

    // item kinds
    typedef enum logic {
        CMD_DATA  = 1'b0,
        CMD_TABLE = 1'b1
    } t_req_kind;

    // input word as seen on the port
    typedef struct packed {
        logic        req_type;
        logic [7:0]  byte_value;
        logic        last;
        logic [7:0]  table_index;
        logic [63:0] table_value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [63:0] feature;
        logic        used_fallback;
    } t_out_word;

    // classified command held in the queue
    typedef struct packed {
        t_req_kind   kind;
        logic [7:0]  byte_value;
        logic        last;
        logic [7:0]  table_index;
        logic [63:0] table_value;
    } t_cmd;

    // mixer request / response
    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } t_mix_req;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } t_mix_rsp;

    // back-end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_OLD,
        BK_ROLL,
        BK_MIXW,
        BK_END,
        BK_MIXF,
        BK_OUT
    } t_back_state;

    // mixer sequencer
    typedef enum logic [2:0] {
        MX_IDLE,
        MX_P0,
        MX_P1,
        MX_P2,
        MX_POST
    } t_mix_state;

endpackage

### rtl/gwmf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwmf_stream_if : valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface gwmf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/gwmf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwmf_front : input stage
// Registers each accepted word, classifies it as data byte or table write
// and offers it to the command queue.
// ----------------------------------------------------------------------------
module gwmf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gwmf_stream_if.sink           i_in,
    output gwmf_pkg::t_cmd        o_cmd,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready
);

    logic           r_full;
    gwmf_pkg::t_cmd r_cmd;
    gwmf_pkg::t_cmd n_cmd;
    logic           accept;

    // stage frees up when empty or drained this cycle
    assign i_in.ready = !r_full || i_cmd_ready;
    assign accept     = i_in.valid && i_in.ready;

    // classify: last only means something on a data byte
    always_comb begin
        n_cmd.kind        = gwmf_pkg::t_req_kind'(i_in.data.req_type);
        n_cmd.byte_value  = i_in.data.byte_value;
        n_cmd.last        = (n_cmd.kind == gwmf_pkg::CMD_DATA) ? i_in.data.last : 1'b0;
        n_cmd.table_index = i_in.data.table_index;
        n_cmd.table_value = i_in.data.table_value;
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (accept) begin
            r_full <= 1'b1;
        end else if (i_cmd_ready) begin
            r_full <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_full;

endmodule

### rtl/gwmf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwmf_queue : command queue
// Small flop FIFO that decouples the front stage from the back end.
// ----------------------------------------------------------------------------
module gwmf_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gwmf_pkg::t_cmd        i_push_cmd,
    input  logic                  i_push_valid,
    output logic                  o_push_ready,
    output gwmf_pkg::t_cmd        o_pop_cmd,
    output logic                  o_pop_valid,
    input  logic                  i_pop_ready
);

    localparam int DEPTH = gwmf_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    gwmf_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

### rtl/gwmf_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwmf_mix : iterative splitmix64 finaliser
// One shared 32x32 multiplier; each 64-bit low product is built from three
// partial products. Two passes of P0, P1, P2, POST precede result and done.
// ----------------------------------------------------------------------------
module gwmf_mix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gwmf_pkg::t_mix_req    i_req,
    output gwmf_pkg::t_mix_rsp    o_rsp
);

    gwmf_pkg::t_mix_state r_state;
    gwmf_pkg::t_mix_state n_state;

    logic [63:0] r_op;
    logic [63:0] r_acc;
    logic        r_second;
    logic [63:0] r_out;
    logic        r_done;

    logic [63:0] pre;
    logic [63:0] kmul;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // first step: add gamma and fold
    assign pre  = i_req.value + gwmf_pkg::SM_GAMMA;
    assign kmul = r_second ? gwmf_pkg::SM_MUL2 : gwmf_pkg::SM_MUL1;

    // shared multiplier: lo*lo, lo*hi, hi*lo
    assign mul_a = (r_state == gwmf_pkg::MX_P2) ? r_op[63:32] : r_op[31:0];
    assign mul_b = (r_state == gwmf_pkg::MX_P1) ? kmul[63:32] : kmul[31:0];
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwmf_pkg::MX_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gwmf_pkg::MX_IDLE: if (i_req.start) n_state = gwmf_pkg::MX_P0;
            gwmf_pkg::MX_P0:   n_state = gwmf_pkg::MX_P1;
            gwmf_pkg::MX_P1:   n_state = gwmf_pkg::MX_P2;
            gwmf_pkg::MX_P2:   n_state = gwmf_pkg::MX_POST;
            gwmf_pkg::MX_POST: n_state = r_second ? gwmf_pkg::MX_IDLE : gwmf_pkg::MX_P0;
            default:           n_state = gwmf_pkg::MX_IDLE;
        endcase
    end

    // done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == gwmf_pkg::MX_POST) && r_second;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            gwmf_pkg::MX_IDLE: begin
                r_op     <= pre ^ (pre >> 30);
                r_second <= 1'b0;
            end
            gwmf_pkg::MX_P0: begin
                r_acc <= mul_p;
            end
            gwmf_pkg::MX_P1, gwmf_pkg::MX_P2: begin
                r_acc[63:32] <= r_acc[63:32] + mul_p[31:0];
            end
            gwmf_pkg::MX_POST: begin
                if (r_second) begin
                    r_out <= r_acc ^ (r_acc >> 31);
                end else begin
                    r_op     <= r_acc ^ (r_acc >> 27);
                    r_second <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_out;

endmodule

### rtl/gwmf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwmf_back : execution back end
// Holds the gear table and the window byte ring, keeps the rolling gear hash,
// the FNV-1a span hash and the running minimum, and drives the result word.
// ----------------------------------------------------------------------------
module gwmf_back #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gwmf_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  logic [gwmf_pkg::CFG_W-1:0]    i_window_size,
    output gwmf_pkg::t_mix_req            o_mix_req,
    input  gwmf_pkg::t_mix_rsp            i_mix_rsp,
    gwmf_stream_if.source                 o_res
);

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int BW    = $clog2(MAX_WINDOW + 1);

    gwmf_pkg::t_back_state r_state;
    gwmf_pkg::t_back_state n_state;

    // memories
    logic [63:0] r_gear [256];
    logic [7:0]  r_win  [DEPTH];
    logic [63:0] r_ga_q;
    logic [63:0] r_gb_q;
    logic [7:0]  r_old_q;

    // span state
    logic [7:0]    r_b;
    logic          r_last;
    logic [BW-1:0] r_span_w;
    logic [BW-1:0] r_bs;
    logic [AW-1:0] r_ptr;
    logic [63:0]   r_roll;
    logic [63:0]   r_fnv;
    logic [63:0]   r_min;
    logic [63:0]   r_res;
    logic          r_res_fb;
    gwmf_pkg::t_out_word r_out;
    logic          r_out_valid;

    logic [BW-1:0] eff_w;
    logic [BW-1:0] cur_w;
    logic [AW-1:0] rd_old_addr;
    logic [63:0]   fnv_x;
    logic [63:0]   fnv_next;
    logic [63:0]   gb_shift;
    logic          full_before;
    logic [63:0]   roll_next;
    logic [BW-1:0] bs_next;
    logic          full_after;
    logic          fallback;
    logic          out_free;
    logic          pop;
    logic          pop_data;
    logic          pop_table;

    // window size clamped to 1..MAX_WINDOW, latched at the first byte of a span
    always_comb begin
        if (i_window_size == '0) begin
            eff_w = BW'(1);
        end else if (int'(i_window_size) > MAX_WINDOW) begin
            eff_w = BW'(MAX_WINDOW);
        end else begin
            eff_w = BW'(i_window_size);
        end
    end

    assign cur_w       = (r_bs == '0) ? eff_w : r_span_w;
    assign rd_old_addr = r_ptr - cur_w[AW-1:0];

    assign pop       = (r_state == gwmf_pkg::BK_IDLE) && i_cmd_valid;
    assign pop_data  = pop && (i_cmd.kind == gwmf_pkg::CMD_DATA);
    assign pop_table = pop && (i_cmd.kind == gwmf_pkg::CMD_TABLE);

    // FNV-1a step
    assign fnv_x    = r_fnv ^ {56'd0, i_cmd.byte_value};
    assign fnv_next = (fnv_x << gwmf_pkg::FNV_PRIME_SHIFT) + fnv_x * gwmf_pkg::FNV_PRIME_LO;

    // rolling gear update; the leaving entry shifted by 64 or more is zero
    assign gb_shift    = r_gb_q << r_span_w;
    assign full_before = (r_bs >= r_span_w);
    assign roll_next   = (r_roll << 1) + r_ga_q - (full_before ? gb_shift : 64'd0);
    assign bs_next     = (r_bs < r_span_w) ? r_bs + BW'(1) : r_bs;
    assign full_after  = (bs_next >= r_span_w);

    // end-of-span choice
    assign fallback = (r_bs < r_span_w) || (r_min == '1);
    assign out_free = !r_out_valid || o_res.ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwmf_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and mixer requests
    always_comb begin
        n_state         = r_state;
        o_mix_req.start = 1'b0;
        o_mix_req.value = (r_state == gwmf_pkg::BK_ROLL) ? roll_next : r_fnv;
        unique case (r_state)
            gwmf_pkg::BK_IDLE: begin
                if (pop_data) n_state = gwmf_pkg::BK_OLD;
            end
            gwmf_pkg::BK_OLD: begin
                n_state = gwmf_pkg::BK_ROLL;
            end
            gwmf_pkg::BK_ROLL: begin
                o_mix_req.start = full_after;
                n_state         = full_after ? gwmf_pkg::BK_MIXW : gwmf_pkg::BK_END;
            end
            gwmf_pkg::BK_MIXW: begin
                if (i_mix_rsp.done) n_state = gwmf_pkg::BK_END;
            end
            gwmf_pkg::BK_END: begin
                if (!r_last) begin
                    n_state = gwmf_pkg::BK_IDLE;
                end else if (fallback) begin
                    o_mix_req.start = 1'b1;
                    n_state         = gwmf_pkg::BK_MIXF;
                end else begin
                    n_state = gwmf_pkg::BK_OUT;
                end
            end
            gwmf_pkg::BK_MIXF: begin
                if (i_mix_rsp.done) n_state = gwmf_pkg::BK_OUT;
            end
            gwmf_pkg::BK_OUT: begin
                if (out_free) n_state = gwmf_pkg::BK_IDLE;
            end
            default: begin
                n_state = gwmf_pkg::BK_IDLE;
            end
        endcase
    end

    assign o_cmd_ready = (r_state == gwmf_pkg::BK_IDLE);

    // gear table and window ring, registered reads
    always_ff @(posedge i_clk) begin
        if (pop_table) begin
            r_gear[i_cmd.table_index] <= i_cmd.table_value;
        end
        if (pop_data) begin
            r_ga_q  <= r_gear[i_cmd.byte_value];
            r_old_q <= r_win[rd_old_addr];
        end
        if (r_state == gwmf_pkg::BK_OLD) begin
            r_gb_q <= r_gear[r_old_q];
        end
        if (r_state == gwmf_pkg::BK_ROLL) begin
            r_win[r_ptr] <= r_b;
        end
    end

    // per-byte payload and result staging
    always_ff @(posedge i_clk) begin
        if (pop_data) begin
            r_b      <= i_cmd.byte_value;
            r_last   <= i_cmd.last;
            r_span_w <= cur_w;
        end
        if (r_state == gwmf_pkg::BK_END) begin
            r_res    <= r_min;
            r_res_fb <= 1'b0;
        end
        if (r_state == gwmf_pkg::BK_MIXF && i_mix_rsp.done) begin
            r_res    <= i_mix_rsp.value;
            r_res_fb <= 1'b1;
        end
        if (r_state == gwmf_pkg::BK_OUT && out_free) begin
            r_out.feature       <= r_res;
            r_out.used_fallback <= r_res_fb;
        end
    end

    // span state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs        <= '0;
            r_ptr       <= '0;
            r_roll      <= '0;
            r_fnv       <= gwmf_pkg::FNV_BASIS;
            r_min       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (pop_data) begin
                r_fnv <= fnv_next;
            end
            if (r_state == gwmf_pkg::BK_ROLL) begin
                r_roll <= roll_next;
                r_ptr  <= r_ptr + AW'(1);
                r_bs   <= bs_next;
            end
            if (r_state == gwmf_pkg::BK_MIXW && i_mix_rsp.done
                && (i_mix_rsp.value < r_min)) begin
                r_min <= i_mix_rsp.value;
            end
            if (r_state == gwmf_pkg::BK_OUT && out_free) begin
                // close the span
                r_bs        <= '0;
                r_roll      <= '0;
                r_fnv       <= gwmf_pkg::FNV_BASIS;
                r_min       <= '1;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

### rtl/gear_window_minhash_feature_top.sv
`timescale 1ns / 1ps
// Each data byte passes back-end states IDLE, OLD, ROLL and END while its window
// fills; once it is full, MIXW after ROLL waits for the shared splitmix64 mixer.
// The closing byte goes on to OUT, through MIXF when the FNV fallback is mixed.
// Table writes happen in IDLE. Input is buffered by a register and a 4-word queue.
// Reset (synchronous, active low) clears the span state and sets window size to 32;
// the gear table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// gear_window_minhash_feature_top : gear hash sliding-window min-hash feature
// Front stage, command queue, back end and splitmix64 mixer.
// ----------------------------------------------------------------------------
module gear_window_minhash_feature_top #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gwmf_pkg::CFG_W-1:0]    i_cfg_wdata,
    gwmf_stream_if.sink                   i_in,
    gwmf_stream_if.source                 o_res
);

    logic [gwmf_pkg::CFG_W-1:0] r_window_size;

    gwmf_pkg::t_cmd     front_cmd;
    logic               front_valid;
    logic               front_ready;
    gwmf_pkg::t_cmd     queue_cmd;
    logic               queue_valid;
    logic               queue_ready;
    gwmf_pkg::t_mix_req mix_req;
    gwmf_pkg::t_mix_rsp mix_rsp;

    // window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= gwmf_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_size <= i_cfg_wdata;
        end
    end

    gwmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    gwmf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cmd   (front_cmd),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_pop_cmd    (queue_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready)
    );

    gwmf_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mix_req),
        .o_rsp   (mix_rsp)
    );

    gwmf_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_cmd_valid   (queue_valid),
        .o_cmd_ready   (queue_ready),
        .i_window_size (r_window_size),
        .o_mix_req     (mix_req),
        .i_mix_rsp     (mix_rsp),
        .o_res         (o_res)
    );

endmodule
